// File: rtl/core/iabst_pkg.sv
`timescale 1ns / 1ps
package iabst_pkg;

	localparam int TREE_SLOTS = 128;
	localparam int IDX_W      = $clog2(TREE_SLOTS);
	localparam int KEY_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 7;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_NO_ROOM   = 3'd2,
		STAT_FOUND     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic advance;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/implicit_array_bst_insert_search.sv
`timescale 1ns / 1ps
// Binary search tree kept in a table of TREE_SLOTS slots; the children of
// slot i are slots 2i+1 (smaller keys) and 2i+2 (larger keys).
// Input stream s_*: tdata carries the signed 32-bit key, tuser the mode
// (0 insert, 1 search). Output stream m_*: tdata carries status and slot.
// Each request walks the tree from the root, one level per cycle: the key
// memory is read once per level through its single registered port, and
// the compare of one level picks the address of the next read.
// A request holds s_tready low from acceptance until its result is loaded
// into the output register and shown on m_tvalid; with 128 slots a walk
// visits at most 8 levels (slot 127 sits one level below slot 63), and the
// next request is taken in the idle state.
// The result waits in an output register, so a new request is taken while
// the receiver stalls; that request finishes its walk and then holds until
// the output register is free.
// Reset clears all used flags at once (empty tree) and the output valid flag;
// no clearing pass is needed, since keys are read only from used slots.
module implicit_array_bst_insert_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key
	input  logic        s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [2:0] status, [9:3] slot, [15:10] zero
);
	import iabst_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	iabst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iabst_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mode    (s_tuser),
		.in_key     (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_slot   (slot)
	);

	assign m_tdata = {{(16 - STATUS_W - SLOT_W){1'b0}}, slot, status};

	// An accepted request takes ready low while it walks the tree.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready stayed high after a request was accepted");

	// Results carry only defined status codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status <= STATUS_W'(STAT_NOT_FOUND)))
		else $error("undefined status code");

	// Only inserted and found results carry a slot.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status == STATUS_W'(STAT_DUPLICATE) ||
		 status == STATUS_W'(STAT_NO_ROOM) || status == STATUS_W'(STAT_NOT_FOUND)))
		|-> (slot == '0))
		else $error("slot not zero for a result without a slot");

	// A finished walk never loads over a result the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

endmodule

// File: rtl/core/iabst_ram.sv
`timescale 1ns / 1ps
module iabst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// File: rtl/core/iabst_ctrl.sv
`timescale 1ns / 1ps
module iabst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  iabst_pkg::sts_t sts,
	output iabst_pkg::cmd_t cmd
);
	import iabst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_STEP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.start   = 1'b0;
		cmd.advance = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_STEP;
				end
			end
			ST_STEP: begin
				if (!sts.done) begin
					cmd.advance = 1'b1;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/iabst_dp.sv
`timescale 1ns / 1ps
module iabst_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_mode,
	input  logic [iabst_pkg::KEY_W-1:0]       in_key,
	input  iabst_pkg::cmd_t                   cmd,
	output iabst_pkg::sts_t                   sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [iabst_pkg::STATUS_W-1:0]    out_status,
	output logic [iabst_pkg::SLOT_W-1:0]      out_slot
);
	import iabst_pkg::*;

	logic                  mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TREE_SLOTS-1:0] used_q;
	logic [KEY_W-1:0]      rdata;

	logic                  used_cur;
	logic                  key_eq;
	logic                  key_lt;
	logic [IDX_W+1:0]      child;
	logic                  child_oob;
	logic                  ram_we;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_addr;
	status_t               res_status;
	logic [SLOT_W-1:0]     res_slot;

	assign used_cur  = used_q[idx_q];
	assign key_eq    = (key_q == $signed(rdata));
	assign key_lt    = (key_q < $signed(rdata));
	// Two spare bits keep the right child of the last slot from wrapping.
	assign child     = {1'b0, idx_q, 1'b0} + (key_lt ? (IDX_W+2)'(1) : (IDX_W+2)'(2));
	assign child_oob = (child >= (IDX_W+2)'(TREE_SLOTS));

	assign sts.done     = !used_cur || key_eq || child_oob;
	assign sts.out_free = !out_valid || out_ready;

	// The key is written when an insert ends on an empty slot.
	assign ram_we   = cmd.finish && (mode_q == MODE_INSERT) && !used_cur;
	assign ram_re   = cmd.start || cmd.advance;
	assign ram_addr = ram_we ? idx_q : (cmd.start ? '0 : child[IDX_W-1:0]);

	iabst_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TREE_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (key_q),
		.rdata (rdata)
	);

	always_comb begin
		res_slot = '0;
		if (!used_cur) begin
			if (mode_q == MODE_INSERT) begin
				res_status = STAT_INSERTED;
				res_slot   = SLOT_W'(idx_q);
			end else begin
				res_status = STAT_NOT_FOUND;
			end
		end else if (key_eq) begin
			if (mode_q == MODE_INSERT) begin
				res_status = STAT_DUPLICATE;
			end else begin
				res_status = STAT_FOUND;
				res_slot   = SLOT_W'(idx_q);
			end
		end else begin
			res_status = (mode_q == MODE_INSERT) ? STAT_NO_ROOM : STAT_NOT_FOUND;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= in_mode;
			key_q  <= in_key;
			idx_q  <= '0;
		end else if (cmd.advance) begin
			idx_q <= child[IDX_W-1:0];
		end
		if (cmd.finish) begin
			out_status <= res_status;
			out_slot   <= res_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (ram_we) begin
				used_q[idx_q] <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
